// File: sv/nearest_neighbor_fit_downscaler_defines.svh
// Assertion macros shared by the downscaler RTL.
`ifndef NEAREST_NEIGHBOR_FIT_DOWNSCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_FIT_DOWNSCALER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NNFD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nnfd check failed");

// Next-cycle implication, checked outside reset.
`define NNFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nnfd check failed");

`endif

// File: sv/nnfd_pkg.sv
// Package: widths, register indexes and types of the fit downscaler.
package nnfd_pkg;

  localparam int DIM_BITS       = 14;
  localparam int ACC_BITS       = 2 * DIM_BITS;
  localparam int COLOR_BITS     = 8;
  localparam int CFG_INDEX_BITS = 2;

  // divider for the short output side: (2*short*m + long) / (2*long)
  localparam int DIV_NUM_BITS   = 2 * DIM_BITS + 2;
  localparam int DIV_DEN_BITS   = DIM_BITS + 1;
  localparam int DIV_COUNT_BITS = $clog2(DIV_NUM_BITS);

  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE_LIMIT    = 2'd2;

  typedef struct packed {
    logic                done;
    logic [DIM_BITS-1:0] quotient;
  } div_result_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  eol;
    logic                  eof;
  } pix_t;

endpackage

// File: sv/nnfd_side_div.sv
// Restoring divider, one quotient bit per cycle, for the scaled output side.
module nnfd_side_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [nnfd_pkg::DIV_NUM_BITS-1:0]    num,
  input  logic [nnfd_pkg::DIV_DEN_BITS-1:0]    den,
  output nnfd_pkg::div_result_t                result
);

  logic                                running;
  logic                                done;
  logic [nnfd_pkg::DIV_COUNT_BITS-1:0] count;
  logic [nnfd_pkg::DIV_NUM_BITS-1:0]   acc;
  logic [nnfd_pkg::DIV_DEN_BITS-1:0]   rem;
  logic [nnfd_pkg::DIV_DEN_BITS-1:0]   den_reg;

  logic [nnfd_pkg::DIV_DEN_BITS:0]     shifted;
  logic [nnfd_pkg::DIV_DEN_BITS:0]     diff;
  logic [nnfd_pkg::DIV_DEN_BITS-1:0]   rem_next;
  logic                                qbit;

  always_comb begin
    shifted = {rem, acc[nnfd_pkg::DIV_NUM_BITS-1]};
    diff    = shifted - {1'b0, den_reg};
    qbit    = ~diff[nnfd_pkg::DIV_DEN_BITS];
    rem_next = qbit ? diff[nnfd_pkg::DIV_DEN_BITS-1:0]
                    : shifted[nnfd_pkg::DIV_DEN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      // a restart on the last step drops the old run's result
      done <= running && (count == '0) && !start;
      if (start) begin
        running <= 1'b1;
        count   <= nnfd_pkg::DIV_COUNT_BITS'(nnfd_pkg::DIV_NUM_BITS - 1);
      end else if (running) begin
        if (count == '0) running <= 1'b0;
        else count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= num;
      rem     <= '0;
      den_reg <= den;
    end else if (running) begin
      acc <= {acc[nnfd_pkg::DIV_NUM_BITS-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign result.done     = done;
  assign result.quotient = acc[nnfd_pkg::DIM_BITS-1:0];

endmodule

// File: sv/nearest_neighbor_fit_downscaler.sv
// Nearest-neighbor fit downscaler: one source pixel in per cycle unless src_stall is high, selected pixels out.
// A selected pixel is registered in the output register, or in the skid stage while the output is held.
// Selection uses running multiples of the output and source sizes.
// A register write restarts the frame and recomputes the output size with a serial
// divider (30 quotient bits); the input stalls until the new size is in place.
// Reset (rst, synchronous): size 1x1, scaling off, counters clear, output empty.
`include "nearest_neighbor_fit_downscaler_defines.svh"

module nearest_neighbor_fit_downscaler (
  input  logic                                   clk,
  input  logic                                   rst,
  // source pixel channel
  input  logic                                   src_valid,
  output logic                                   src_stall,
  input  logic [nnfd_pkg::COLOR_BITS-1:0]        red_in,
  input  logic [nnfd_pkg::COLOR_BITS-1:0]        green_in,
  input  logic [nnfd_pkg::COLOR_BITS-1:0]        blue_in,
  // output pixel channel
  output logic                                   dst_valid,
  input  logic                                   dst_stall,
  output logic [nnfd_pkg::COLOR_BITS-1:0]        red_out,
  output logic [nnfd_pkg::COLOR_BITS-1:0]        green_out,
  output logic [nnfd_pkg::COLOR_BITS-1:0]        blue_out,
  output logic                                   end_of_line,
  output logic                                   end_of_frame,
  // configuration write port
  input  logic                                   cfg_write,
  input  logic [nnfd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [nnfd_pkg::DIM_BITS-1:0]          cfg_data
);

  localparam int DB = nnfd_pkg::DIM_BITS;
  localparam int AB = nnfd_pkg::ACC_BITS;

  // configuration registers
  logic [DB-1:0] source_width;
  logic [DB-1:0] source_height;
  logic [DB-1:0] side_limit;

  // output size and its computation
  logic [DB-1:0] output_width;
  logic [DB-1:0] output_height;
  logic          pend;        // size recompute requested
  logic          calc;        // divider running
  logic          wide;        // width is the long side of the frame being sized
  logic [DB-1:0] calc_max;

  // frame position
  logic [DB-1:0] source_column, source_row;
  logic [DB-1:0] output_column, output_row;
  logic [AB-1:0] column_accumulator, row_accumulator;   // output pos * source size
  logic [AB-1:0] column_base, row_base;                 // source pos * output size

  // output register and skid stage
  nnfd_pkg::pix_t dst_pix, skid_pix, new_pix;
  logic           skid_valid;

  // ---------------------------------------------------------------------------
  // Output size setup: when a side exceeds a nonzero side_limit, the long side becomes
  // side_limit and the short side is round-half-up(short*m/long) done by the divider; else the source size.
  // ---------------------------------------------------------------------------
  logic [DB-1:0] eff_w, eff_h, long_side, short_side;
  logic          need_scale, is_wide;
  logic [AB-1:0] prod;
  logic [nnfd_pkg::DIV_NUM_BITS-1:0] div_num;
  logic [nnfd_pkg::DIV_DEN_BITS-1:0] div_den;
  logic          div_start;
  nnfd_pkg::div_result_t div_res;
  logic [DB-1:0] short_out;

  always_comb begin
    eff_w      = (source_width  == '0) ? DB'(1) : source_width;
    eff_h      = (source_height == '0) ? DB'(1) : source_height;
    need_scale = (side_limit != '0) && ((eff_w > side_limit) || (eff_h > side_limit));
    is_wide    = eff_w >= eff_h;
    long_side  = is_wide ? eff_w : eff_h;
    short_side = is_wide ? eff_h : eff_w;
    prod       = AB'(short_side) * AB'(side_limit);
    div_num    = {1'b0, prod, 1'b0} + nnfd_pkg::DIV_NUM_BITS'(long_side);
    div_den    = {long_side, 1'b0};
    div_start  = pend && need_scale;
    short_out  = (div_res.quotient == '0) ? DB'(1) : div_res.quotient;
  end

  nnfd_side_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .result (div_res)
  );

  // ---------------------------------------------------------------------------
  // Pixel selection: source row r is picked while r*Dh <= output_row*H < (r+1)*Dh,
  // which is floor(output_row*H/Dh) == r without a divide. Columns likewise.
  // ---------------------------------------------------------------------------
  logic          accept, produce, dst_take;
  logic          row_sel, col_sel, sel, eol, eof;
  logic [AB:0]   row_top, col_top;
  logic          last_col, last_row;

  always_comb begin
    accept   = src_valid && !src_stall;
    dst_take = dst_valid && !dst_stall;
    row_top  = {1'b0, row_base}    + (AB+1)'(output_height);
    col_top  = {1'b0, column_base} + (AB+1)'(output_width);
    row_sel  = (output_row < output_height) && (row_accumulator >= row_base) &&
               ({1'b0, row_accumulator} < row_top);
    col_sel  = (output_column < output_width) && (column_accumulator >= column_base) &&
               ({1'b0, column_accumulator} < col_top);
    sel      = row_sel && col_sel;
    produce  = accept && sel;
    eol      = ({1'b0, output_column} + 1'b1) == {1'b0, output_width};
    eof      = eol && (({1'b0, output_row} + 1'b1) == {1'b0, output_height});
    last_col = ({1'b0, source_column} + 1'b1) >= {1'b0, eff_w};
    last_row = ({1'b0, source_row} + 1'b1) >= {1'b0, eff_h};
    new_pix.red   = red_in;
    new_pix.green = green_in;
    new_pix.blue  = blue_in;
    new_pix.eol   = eol;
    new_pix.eof   = eof;
  end

  // No new pixel while the skid holds one or the output size is being worked out.
  assign src_stall = skid_valid || pend || calc;

  // configuration and output size; a pending write overrides a finishing divide
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= DB'(1);
      source_height <= DB'(1);
      side_limit    <= '0;
      output_width  <= DB'(1);
      output_height <= DB'(1);
      pend          <= 1'b0;
      calc          <= 1'b0;
    end else begin
      // a divide superseded by an unscaled write finishes with calc low: dropped
      if (div_res.done && calc) begin
        calc <= 1'b0;
        if (wide) begin
          output_width  <= calc_max;
          output_height <= short_out;
        end else begin
          output_width  <= short_out;
          output_height <= calc_max;
        end
      end
      if (pend) begin
        pend <= 1'b0;
        if (need_scale) begin
          calc     <= 1'b1;
          wide     <= is_wide;
          calc_max <= side_limit;
        end else begin
          calc          <= 1'b0;
          output_width  <= eff_w;
          output_height <= eff_h;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          nnfd_pkg::REG_SOURCE_WIDTH: begin
            source_width <= cfg_data;
            pend <= 1'b1;
          end
          nnfd_pkg::REG_SOURCE_HEIGHT: begin
            source_height <= cfg_data;
            pend <= 1'b1;
          end
          nnfd_pkg::REG_SIDE_LIMIT: begin
            side_limit <= cfg_data;
            pend <= 1'b1;
          end
          default: ;  // index beyond the register list: ignored
        endcase
      end
    end
  end

  // frame position; a register write restarts the frame
  logic cfg_hit;
  assign cfg_hit = cfg_write && ((cfg_index == nnfd_pkg::REG_SOURCE_WIDTH) ||
                                 (cfg_index == nnfd_pkg::REG_SOURCE_HEIGHT) ||
                                 (cfg_index == nnfd_pkg::REG_SIDE_LIMIT));

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      source_column      <= '0;
      source_row         <= '0;
      output_column      <= '0;
      output_row         <= '0;
      column_accumulator <= '0;
      row_accumulator    <= '0;
      column_base        <= '0;
      row_base           <= '0;
    end else if (accept) begin
      if (sel) begin
        output_column      <= output_column + 1'b1;
        column_accumulator <= column_accumulator + AB'(eff_w);
      end
      if (last_col) begin
        source_column      <= '0;
        column_base        <= '0;
        output_column      <= '0;
        column_accumulator <= '0;
        if (row_sel) begin
          output_row      <= output_row + 1'b1;
          row_accumulator <= row_accumulator + AB'(eff_h);
        end
        if (last_row) begin
          // frame wraps: next pixel starts a new frame
          source_row      <= '0;
          row_base        <= '0;
          output_row      <= '0;
          row_accumulator <= '0;
        end else begin
          source_row <= source_row + 1'b1;
          row_base   <= row_base + AB'(output_height);
        end
      end else begin
        source_column <= source_column + 1'b1;
        column_base   <= column_base + AB'(output_width);
      end
    end
  end

  // output register with a one-item skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (dst_take || !dst_valid) begin
      if (skid_valid) begin
        dst_pix    <= skid_pix;
        dst_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (produce) begin
        dst_pix   <= new_pix;
        dst_valid <= 1'b1;
      end else begin
        dst_valid <= 1'b0;
      end
    end else if (produce) begin
      skid_pix   <= new_pix;
      skid_valid <= 1'b1;
    end
  end

  assign red_out      = dst_pix.red;
  assign green_out    = dst_pix.green;
  assign blue_out     = dst_pix.blue;
  assign end_of_line  = dst_pix.eol;
  assign end_of_frame = dst_pix.eof;

  // checks
  `NNFD_ASSERT_IMP(a_skid_behind_out, skid_valid, dst_valid)
  `NNFD_ASSERT_IMP(a_stall_while_sizing, pend || calc, src_stall)
  `NNFD_ASSERT_IMP(a_eof_has_eol, dst_valid && end_of_frame, end_of_line)
  `NNFD_ASSERT_IMP(a_out_pos_bound, 1'b1,
                   (output_column <= output_width) && (output_row <= output_height))
  `NNFD_ASSERT_NEXT(a_write_stalls_input, cfg_hit, src_stall)

endmodule

// File: tb/tb_nearest_neighbor_fit_downscaler.sv
// Testbench for the fit downscaler: random frame sizes and pixels, checked by a predictor.
module tb_nearest_neighbor_fit_downscaler;

  typedef longint unsigned u64_t;
  typedef logic [nnfd_pkg::DIM_BITS-1:0]       dim_t;
  typedef logic [nnfd_pkg::ACC_BITS-1:0]       acc_t;
  typedef logic [nnfd_pkg::COLOR_BITS-1:0]     color_t;
  typedef logic [nnfd_pkg::CFG_INDEX_BITS-1:0] index_t;

  // the one index past the register file; a write there must be a no-op
  localparam index_t REG_UNUSED = 2'd3;

  localparam int MAX_DIM_VALUE  = (1 << nnfd_pkg::DIM_BITS) - 1;
  localparam int ITEMS_TARGET   = 1500;  // total pixels sent, random phases included
  localparam int SETTLE_CYCLES  = 40;    // wait before a write, so the size divider of the last write can finish
  localparam int DRAIN_CYCLES   = 4;     // extra wait once no kept pixel is pending
  localparam int HOLDOFF_CYCLES = 150;   // long receiver stall, fills the block
  localparam int QUIET_LIMIT    = 5000;  // cycles with no handshake at all
  localparam int IDLE_PERCENT   = 35;
  localparam int MAX_REPORTS    = 40;

  // Predicts which source pixels are kept and with which line/frame marks,
  // and holds the kept pixels until the block delivers them.
  class fit_downscale_scoreboard;
    nnfd_pkg::pix_t selected_pixels_q[$];
    dim_t src_w, src_h, max_dim;
    dim_t src_col, src_row, dst_col, dst_row, dst_w, dst_h;
    acc_t col_acc, row_acc;
    int   errors;

    function new();
      src_w   = 1;
      src_h   = 1;
      max_dim = 0;
      errors  = 0;
      fit_output_size();
    endfunction

    // a zero source side counts as one
    function u64_t eff(dim_t side);
      return (side == 0) ? u64_t'(1) : u64_t'(side);
    endfunction

    // short output side: round(short * m / long) half up, never below one
    function u64_t short_side(u64_t s, u64_t m, u64_t l);
      u64_t q;
      q = (2 * s * m + l) / (2 * l);
      return (q < 1) ? u64_t'(1) : q;
    endfunction

    // output size from the registers; every write restarts the frame
    function void fit_output_size();
      u64_t w, h, m;
      w = eff(src_w);
      h = eff(src_h);
      m = u64_t'(max_dim);
      dst_w = dim_t'(w);
      dst_h = dim_t'(h);
      if (m != 0 && (w > m || h > m)) begin
        if (w >= h) begin
          dst_w = dim_t'(m);
          dst_h = dim_t'(short_side(h, m, w));
        end else begin
          dst_h = dim_t'(m);
          dst_w = dim_t'(short_side(w, m, h));
        end
      end
      src_col = '0;
      src_row = '0;
      dst_col = '0;
      dst_row = '0;
      col_acc = '0;
      row_acc = '0;
    endfunction

    function void write_register(index_t index, dim_t data);
      case (index)
        nnfd_pkg::REG_SOURCE_WIDTH:  src_w = data;
        nnfd_pkg::REG_SOURCE_HEIGHT: src_h = data;
        nnfd_pkg::REG_SIDE_LIMIT:    max_dim = data;
        default: return;
      endcase
      fit_output_size();
    endfunction

    function void take_source_pixel(color_t r, g, b);
      u64_t w, h;
      logic row_hit, col_hit;
      nnfd_pkg::pix_t px;
      w = eff(src_w);
      h = eff(src_h);
      row_hit = (dst_row < dst_h) && (u64_t'(row_acc) / u64_t'(dst_h) == u64_t'(src_row));
      col_hit = (dst_col < dst_w) && (u64_t'(col_acc) / u64_t'(dst_w) == u64_t'(src_col));
      if (row_hit && col_hit) begin
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.eol   = (u64_t'(dst_col) + 1 == u64_t'(dst_w));
        px.eof   = px.eol && (u64_t'(dst_row) + 1 == u64_t'(dst_h));
        selected_pixels_q.push_back(px);
        dst_col = dst_col + 1'b1;
        col_acc = acc_t'(u64_t'(col_acc) + w);
      end
      if (u64_t'(src_col) + 1 >= w) begin
        src_col = '0;
        dst_col = '0;
        col_acc = '0;
        if (row_hit) begin
          dst_row = dst_row + 1'b1;
          row_acc = acc_t'(u64_t'(row_acc) + h);
        end
        // past the last source pixel the counters wrap into a new frame
        if (u64_t'(src_row) + 1 >= h) begin
          src_row = '0;
          dst_row = '0;
          row_acc = '0;
        end else begin
          src_row = src_row + 1'b1;
        end
      end else begin
        src_col = src_col + 1'b1;
      end
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_output_pixel(nnfd_pkg::pix_t got);
      nnfd_pkg::pix_t want;
      if (selected_pixels_q.size() == 0) begin
        report_mismatch($sformatf("pixel %0h/%0h/%0h out with none pending",
                                  got.red, got.green, got.blue));
        return;
      end
      want = selected_pixels_q.pop_front();
      if (got.red !== want.red)
        report_mismatch($sformatf("red_out %0h, want %0h", got.red, want.red));
      if (got.green !== want.green)
        report_mismatch($sformatf("green_out %0h, want %0h", got.green, want.green));
      if (got.blue !== want.blue)
        report_mismatch($sformatf("blue_out %0h, want %0h", got.blue, want.blue));
      if (got.eol !== want.eol)
        report_mismatch($sformatf("end_of_line %0b, want %0b", got.eol, want.eol));
      if (got.eof !== want.eof)
        report_mismatch($sformatf("end_of_frame %0b, want %0b", got.eof, want.eof));
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   src_valid = 1'b0;
  logic   src_stall;
  color_t red_in = '0;
  color_t green_in = '0;
  color_t blue_in = '0;
  logic   dst_valid;
  logic   dst_stall = 1'b0;
  color_t red_out;
  color_t green_out;
  color_t blue_out;
  logic   end_of_line;
  logic   end_of_frame;
  logic   cfg_write = 1'b0;
  index_t cfg_index = '0;
  dim_t   cfg_data = '0;

  bit idling = 1'b1;       // random gaps on both sides when set
  int holdoff_asked = 0;   // bumped by the stimulus to ask the receiver for a long stall
  int quiet_cycles = 0;
  int items_sent = 0;

  fit_downscale_scoreboard sb = new();

  nearest_neighbor_fit_downscaler dut (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .dst_valid    (dst_valid),
    .dst_stall    (dst_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor. Output is checked before the input is noted: a pixel taken at
  // this edge can only show up on a later one.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_register(cfg_index, cfg_data);
      if (dst_valid && !dst_stall)
        sb.check_output_pixel({red_out, green_out, blue_out, end_of_line, end_of_frame});
      if (src_valid && !src_stall) sb.take_source_pixel(red_in, green_in, blue_in);
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst || cfg_write || (src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_nearest_neighbor_fit_downscaler: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, or none while idling is off; on request it holds
  // off for a long stretch so the block backs up into its input.
  initial begin : receiver
    int seen;
    seen = 0;
    forever begin
      @(posedge clk);
      if (holdoff_asked != seen) begin
        seen = holdoff_asked;
        dst_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      if (idling) dst_stall <= ($urandom_range(99) < IDLE_PERCENT);
      else dst_stall <= 1'b0;
    end
  end

  // One source pixel; returns at the edge that takes it. Valid stays up so a
  // following pixel can go out back to back.
  task automatic send_pixel(color_t r, g, b);
    while (idling && $urandom_range(99) < IDLE_PERCENT) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    red_in    <= r;
    green_in  <= g;
    blue_in   <= b;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_pixels(int n);
    for (int k = 0; k < n; k++)
      send_pixel(color_t'($urandom), color_t'($urandom), color_t'($urandom));
  endtask

  // Sender goes quiet until every kept pixel has come out.
  task automatic wait_until_drained();
    src_valid <= 1'b0;
    while (sb.selected_pixels_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write once the block has settled (size divider done).
  task automatic write_reg(index_t index, dim_t data);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (src_stall) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // All three registers in a rotated order, now and then a stray write to
  // the unused index as well.
  task automatic configure(dim_t w, dim_t h, dim_t m);
    int first;
    first = $urandom_range(2);
    wait_until_drained();
    for (int k = 0; k < 3; k++)
      case ((first + k) % 3)
        0: write_reg(nnfd_pkg::REG_SOURCE_WIDTH, w);
        1: write_reg(nnfd_pkg::REG_SOURCE_HEIGHT, h);
        default: write_reg(nnfd_pkg::REG_SIDE_LIMIT, m);
      endcase
    if ($urandom_range(7) == 0) write_reg(REG_UNUSED, dim_t'($urandom));
  endtask

  initial begin : stimulus
    dim_t w, h, m;
    int   n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset size is 1x1 with scaling off: each pixel is a frame of its own
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);

    // zero width counts as one: a 1x3 column passes straight through
    configure(dim_t'(0), dim_t'(3), dim_t'(0));
    send_pixel(8'h01, 8'h80, 8'hFE);
    send_pixel(8'hFE, 8'h7F, 8'h01);
    // unused index: the frame position must survive the write
    wait_until_drained();
    write_reg(REG_UNUSED, dim_t'(MAX_DIM_VALUE));
    send_random_pixels(3);

    // 4x2 into a square of 2 gives 2x1, two of the eight pixels kept; the last
    // two pixels run past the frame and start the next one
    configure(dim_t'(4), dim_t'(2), dim_t'(2));
    send_random_pixels(10);

    // largest source into a 1x1 square: only the very first pixel survives
    configure(dim_t'(MAX_DIM_VALUE), dim_t'(MAX_DIM_VALUE), dim_t'(1));
    send_random_pixels(3);

    // Back pressure: receiver holds off while pixels keep coming, then the
    // sender pauses mid-frame until everything pending is out.
    configure(dim_t'(8), dim_t'(8), dim_t'(0));
    idling <= 1'b0;
    send_random_pixels(10);
    holdoff_asked <= holdoff_asked + 1;
    send_random_pixels(40);
    idling <= 1'b1;
    send_random_pixels(10);
    wait_until_drained();
    send_random_pixels(20);

    // Random phases: mostly small frames run past their end, some medium
    // wide frames, a few at the register extremes (only a piece of a frame).
    while (items_sent < ITEMS_TARGET) begin
      idling <= ($urandom_range(3) != 0);
      case ($urandom_range(19))
        0, 1: begin
          w = ($urandom_range(1) != 0) ? dim_t'(MAX_DIM_VALUE) : dim_t'($urandom);
          h = ($urandom_range(1) != 0) ? dim_t'(MAX_DIM_VALUE) : dim_t'($urandom);
          case ($urandom_range(3))
            0: m = dim_t'(0);
            1: m = dim_t'(1);
            2: m = dim_t'(MAX_DIM_VALUE);
            default: m = dim_t'($urandom);
          endcase
          n = $urandom_range(5, 40);
        end
        2, 3, 4: begin
          w = dim_t'($urandom_range(1, 200));
          h = dim_t'($urandom_range(1, 6));
          m = dim_t'($urandom_range(64));
          n = int'(w) * int'(h) + $urandom_range(3);
          if (n > 300) n = 300;
        end
        default: begin
          w = dim_t'($urandom_range(12));
          h = dim_t'($urandom_range(12));
          m = dim_t'($urandom_range(14));
          n = (w == 0 ? 1 : int'(w)) * (h == 0 ? 1 : int'(h)) * $urandom_range(1, 2)
              + $urandom_range(3);
        end
      endcase
      configure(w, h, m);
      send_random_pixels(n);
    end

    idling <= 1'b1;
    wait_until_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.selected_pixels_q.size() == 0)
      $display("tb_nearest_neighbor_fit_downscaler: PASS");
    else
      $display("tb_nearest_neighbor_fit_downscaler: FAIL");
    $finish;
  end

endmodule
